@@ rtl/gcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants of the great-circle distance datapath.
// ----------------------------------------------------------------------------
package gcd_pkg;

   // Signed word of the CORDIC datapath (Q30 values with growth headroom).
   localparam int CW = 34;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
   localparam logic signed [CW-1:0] HALF_TURN   = 34'sd2147483648;
   localparam logic [60:0]          ONE_Q60     = 61'h1000_0000_0000_0000;
   localparam logic [30:0]          PI_Q29      = 31'd1686629713;
   localparam logic [32:0]          DIST_MAX    = 33'd5227610176;
   localparam logic [22:0]          RADIUS_RESET = 23'd6378137;

   // Register index of the sphere radius on the configuration port.
   localparam logic CSR_RADIUS = 1'b0;

   // One request as it travels from the front end to the back end.
   typedef struct packed {
      logic [31:0] lat_a;
      logic [31:0] lat_b;
      logic [31:0] half_dlat;
      logic [31:0] half_dlon;
   } gcd_item_type;

   // Arctangent of 2^-k as a binary angle.
   function automatic logic signed [CW-1:0] atan_angle(input logic [4:0] k);
      logic signed [CW-1:0] a;
      unique case (k)
         5'd0:  a = 34'sd536870912;
         5'd1:  a = 34'sd316933406;
         5'd2:  a = 34'sd167458907;
         5'd3:  a = 34'sd85004756;
         5'd4:  a = 34'sd42667331;
         5'd5:  a = 34'sd21354465;
         5'd6:  a = 34'sd10679838;
         5'd7:  a = 34'sd5340245;
         5'd8:  a = 34'sd2670163;
         5'd9:  a = 34'sd1335087;
         5'd10: a = 34'sd667544;
         5'd11: a = 34'sd333772;
         5'd12: a = 34'sd166886;
         5'd13: a = 34'sd83443;
         5'd14: a = 34'sd41722;
         5'd15: a = 34'sd20861;
         5'd16: a = 34'sd10430;
         5'd17: a = 34'sd5215;
         5'd18: a = 34'sd2608;
         5'd19: a = 34'sd1304;
         5'd20: a = 34'sd652;
         5'd21: a = 34'sd326;
         5'd22: a = 34'sd163;
         5'd23: a = 34'sd81;
         5'd24: a = 34'sd41;
         5'd25: a = 34'sd20;
         5'd26: a = 34'sd10;
         5'd27: a = 34'sd5;
         5'd28: a = 34'sd3;
         5'd29: a = 34'sd1;
         5'd30: a = 34'sd1;
         5'd31: a = 34'sd0;
      endcase
      return a;
   endfunction

endpackage

@@ rtl/gcd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_front
// Accepts requests, forms the half-angle differences and queues them.
// ----------------------------------------------------------------------------
module gcd_front import gcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [31:0]  req_lat_a,
   input  logic [31:0]  req_lon_a,
   input  logic [31:0]  req_lat_b,
   input  logic [31:0]  req_lon_b,
   output logic         item_valid,
   output gcd_item_type item
);

   gcd_item_type entry_ff [0:1];
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         push, pop;
   logic [31:0]  dlat, dlon;

   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   // The back end never stalls, so the head leaves as soon as it is there.
   assign pop        = (count_ff != 2'd0);
   assign item_valid = pop;
   assign item       = entry_ff[rd_ptr_ff];

   assign dlat = req_lat_b - req_lat_a;
   assign dlon = req_lon_b - req_lon_a;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{lat_a:     req_lat_a,
                                  lat_b:     req_lat_b,
                                  half_dlat: {1'b0, dlat[31:1]},
                                  half_dlon: {1'b0, dlon[31:1]}};
      end
   end

endmodule

@@ rtl/gcd_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sincos
// Pipelined rotation-mode CORDIC: Q30 cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; #(
   parameter int STAGES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          angle,
   output logic                 out_valid,
   output logic signed [CW-1:0] cos_out,
   output logic signed [CW-1:0] sin_out
);

   logic signed [CW-1:0] x_ff [0:STAGES];
   logic signed [CW-1:0] y_ff [0:STAGES];
   logic signed [CW-1:0] z_ff [0:STAGES];
   logic                 neg_ff [0:STAGES];
   logic [STAGES:0]      vld_ff;
   logic signed [CW-1:0] z_full, z_in;
   logic                 neg_in;

   // Fold the angle into [-90, 90] degrees and negate the result afterwards.
   assign z_full = {{2{angle[31]}}, angle};
   always_comb begin
      z_in   = z_full;
      neg_in = 1'b0;
      if (z_full > ONE_Q30) begin
         z_in   = z_full - HALF_TURN;
         neg_in = 1'b1;
      end else if (z_full < -ONE_Q30) begin
         z_in   = z_full + HALF_TURN;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= CORDIC_GAIN;
      y_ff[0]   <= '0;
      z_ff[0]   <= z_in;
      neg_ff[0] <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-1:0], in_valid};
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [4:0] K = 5'(i);
      logic signed [CW-1:0] xs, ys;
      assign xs = x_ff[i] >>> K;
      assign ys = y_ff[i] >>> K;
      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - atan_angle(K);
         end else begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + atan_angle(K);
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign cos_out   = neg_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
   assign sin_out   = neg_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];

endmodule

@@ rtl/gcd_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [60:0] radicand,
   output logic        out_valid,
   output logic [30:0] root
);

   localparam int NS = 31;

   logic [34:0] rem_ff  [0:NS];
   logic [30:0] root_ff [0:NS];
   logic [61:0] rest_ff [0:NS];
   logic [NS:0] vld_ff;

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rest_ff[0] <= {1'b0, radicand};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NS-1:0], in_valid};
      end
   end

   for (genvar j = 0; j < NS; j++) begin : g_stage
      logic [34:0] rem_n, trial;
      assign rem_n = {rem_ff[j][32:0], rest_ff[j][61:60]};
      assign trial = {2'b00, root_ff[j], 2'b01};
      always_ff @(posedge clock) begin
         rest_ff[j+1] <= {rest_ff[j][59:0], 2'b00};
         if (rem_n >= trial) begin
            rem_ff[j+1]  <= rem_n - trial;
            root_ff[j+1] <= {root_ff[j][29:0], 1'b1};
         end else begin
            rem_ff[j+1]  <= rem_n;
            root_ff[j+1] <= {root_ff[j][29:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign root      = root_ff[NS];

endmodule

@@ rtl/gcd_atan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_atan
// Pipelined vectoring-mode CORDIC: angle of a first-quadrant vector.
// ----------------------------------------------------------------------------
module gcd_atan import gcd_pkg::*; #(
   parameter int STAGES = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [30:0]          x_in,
   input  logic [30:0]          y_in,
   output logic                 out_valid,
   output logic signed [CW-1:0] angle
);

   logic signed [CW-1:0] x_ff [0:STAGES];
   logic signed [CW-1:0] y_ff [0:STAGES];
   logic signed [CW-1:0] z_ff [0:STAGES];
   logic [STAGES:0]      vld_ff;

   always_ff @(posedge clock) begin
      x_ff[0] <= {3'b000, x_in};
      y_ff[0] <= {3'b000, y_in};
      z_ff[0] <= '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-1:0], in_valid};
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [4:0] K = 5'(i);
      logic signed [CW-1:0] xs, ys;
      assign xs = x_ff[i] >>> K;
      assign ys = y_ff[i] >>> K;
      always_ff @(posedge clock) begin
         if (y_ff[i] > 0) begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + atan_angle(K);
         end else begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - atan_angle(K);
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign angle     = z_ff[STAGES];

endmodule

@@ rtl/gcd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_back
// Haversine datapath: trig, products, square roots, arcsine and scaling.
// ----------------------------------------------------------------------------
module gcd_back import gcd_pkg::*; #(
   parameter int STAGES = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  gcd_item_type item,
   input  logic [22:0]  radius,
   output logic         rsp_valid,
   output logic [32:0]  rsp_distance
);

   logic                 trig_valid;
   logic signed [CW-1:0] cos_a, cos_b, sin_lat, sin_lon;
   logic [31:0]          slat_abs, slon_abs;
   logic signed [67:0]   prod_c, prod_u, prod_t;
   logic signed [63:0]   fsum;
   logic [60:0]          f_in;

   logic [3:0]           mvld_ff;
   logic [60:0]          hlat1_ff, hlat2_ff, hlat3_ff;
   logic signed [CW-1:0] t_ff, u_ff;
   logic [31:0]          slon1_ff, slon2_ff;
   logic signed [63:0]   term_ff;
   logic [60:0]          f_ff, g_ff;

   logic                 sq_valid;
   logic [30:0]          root_f, root_g;
   logic                 at_valid;
   logic signed [CW-1:0] theta;
   logic [30:0]          theta_c;
   logic [61:0]          wp;
   logic [39:0]          w_ff;
   logic                 wvld_ff;
   logic [62:0]          dp;
   logic [32:0]          dist_in;
   logic                 ovld_ff;
   logic [32:0]          dist_ff;

   gcd_sincos #(.STAGES(STAGES)) u_trig_lat_a (
      .clock, .reset, .in_valid(item_valid), .angle(item.lat_a),
      .out_valid(trig_valid), .cos_out(cos_a), .sin_out());
   gcd_sincos #(.STAGES(STAGES)) u_trig_lat_b (
      .clock, .reset, .in_valid(item_valid), .angle(item.lat_b),
      .out_valid(), .cos_out(cos_b), .sin_out());
   gcd_sincos #(.STAGES(STAGES)) u_trig_dlat (
      .clock, .reset, .in_valid(item_valid), .angle(item.half_dlat),
      .out_valid(), .cos_out(), .sin_out(sin_lat));
   gcd_sincos #(.STAGES(STAGES)) u_trig_dlon (
      .clock, .reset, .in_valid(item_valid), .angle(item.half_dlon),
      .out_valid(), .cos_out(), .sin_out(sin_lon));

   assign slat_abs = sin_lat[CW-1] ? 32'(-sin_lat) : sin_lat[31:0];
   assign slon_abs = sin_lon[CW-1] ? 32'(-sin_lon) : sin_lon[31:0];

   assign prod_c = cos_a * cos_b;
   assign prod_u = t_ff * $signed({2'b00, slon1_ff});
   assign prod_t = u_ff * $signed({2'b00, slon2_ff});

   // The cosine term may be negative for out-of-range latitudes, so clamp.
   assign fsum = $signed({3'b000, hlat3_ff}) + term_ff;
   always_comb begin
      if (fsum < 0) begin
         f_in = '0;
      end else if (fsum > $signed({3'b000, ONE_Q60})) begin
         f_in = ONE_Q60;
      end else begin
         f_in = fsum[60:0];
      end
   end

   always_ff @(posedge clock) begin
      hlat1_ff <= 61'(slat_abs * slat_abs);
      t_ff     <= prod_c[63:30];
      slon1_ff <= slon_abs;
      hlat2_ff <= hlat1_ff;
      u_ff     <= prod_u[63:30];
      slon2_ff <= slon1_ff;
      hlat3_ff <= hlat2_ff;
      term_ff  <= prod_t[63:0];
      f_ff     <= f_in;
      g_ff     <= ONE_Q60 - f_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= '0;
      end else begin
         mvld_ff <= {mvld_ff[2:0], trig_valid};
      end
   end

   gcd_isqrt u_sqrt_f (
      .clock, .reset, .in_valid(mvld_ff[3]), .radicand(f_ff),
      .out_valid(sq_valid), .root(root_f));
   gcd_isqrt u_sqrt_g (
      .clock, .reset, .in_valid(mvld_ff[3]), .radicand(g_ff),
      .out_valid(), .root(root_g));

   gcd_atan #(.STAGES(STAGES)) u_asin (
      .clock, .reset, .in_valid(sq_valid), .x_in(root_g), .y_in(root_f),
      .out_valid(at_valid), .angle(theta));

   always_comb begin
      if (theta < 0) begin
         theta_c = '0;
      end else if (theta > ONE_Q30) begin
         theta_c = 31'(ONE_Q30);
      end else begin
         theta_c = theta[30:0];
      end
   end

   assign wp = 62'(theta_c * PI_Q29) + 62'd1048576;
   assign dp = 63'(radius * w_ff) + 63'd536870912;
   assign dist_in = (dp[62:30] > DIST_MAX) ? DIST_MAX : dp[62:30];

   always_ff @(posedge clock) begin
      w_ff    <= wp[60:21];
      dist_ff <= dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvld_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else begin
         wvld_ff <= at_valid;
         ovld_ff <= wvld_ff;
      end
   end

   assign rsp_valid    = ovld_ff;
   assign rsp_distance = dist_ff;

endmodule

@@ rtl/great_circle_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine great-circle distance between two points given as binary angles.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  request   start / busy           req_lat_a, req_lon_a, req_lat_b, req_lon_b
//  response  rsp_valid (one cycle)  rsp_distance
//  config    APB psel/penable/...   sphere radius at address 0
//
// One request is taken per cycle while busy is low; the response delay comes
// from the two CORDIC pipelines, the 31-stage square-root pipeline and glue.
// Reset clears the queue and all valid flags and loads the default radius.
// The response side cannot stall, so busy only rises if the queue fills.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_lat_a,
   input  logic [31:0] req_lon_a,
   input  logic [31:0] req_lat_b,
   input  logic [31:0] req_lon_b,
   output logic        rsp_valid,
   output logic [32:0] rsp_distance,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic         item_valid;
   gcd_item_type item;
   logic [22:0]  radius_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_RADIUS) ? {9'd0, radius_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_RADIUS) begin
         radius_ff <= pwdata[22:0];
      end
   end

   gcd_front u_front (
      .clock, .reset, .start, .busy,
      .req_lat_a, .req_lon_a, .req_lat_b, .req_lon_b,
      .item_valid, .item);

   gcd_back #(.STAGES(CORDIC_STAGES)) u_back (
      .clock, .reset, .item_valid, .item, .radius(radius_ff),
      .rsp_valid, .rsp_distance);

endmodule

@@ bench/great_circle_distance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_checker
// Watches the request, response and register ports of the distance block,
// predicts each distance with a bit-exact CORDIC/haversine model of its own
// and compares every response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module great_circle_distance_checker import gcd_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_lat_a,
   input  logic [31:0] req_lon_a,
   input  logic [31:0] req_lat_b,
   input  logic [31:0] req_lon_b,
   input  logic        rsp_valid,
   input  logic [32:0] rsp_distance,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          outstanding
);

   localparam longint ARCTAN [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
   localparam longint Q30_ONE  = 64'sd1 << 30;
   localparam longint Q60_ONE  = 64'sd1 << 60;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam logic [63:0] PI_HALF_Q29 = 64'd1686629713;

   logic [22:0] radius_m;
   logic [32:0] expected_distance [$];

   function automatic void cordic_sincos(input logic [31:0] a, output longint c,
                                         output longint s);
      longint z, x, y, nx;
      bit     flip;
      int     k;
      z = longint'(signed'(a));
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      // Fold the angle into the right half-plane; the result is negated back.
      if (z > Q30_ONE) begin
         z -= 64'sd1 << 31;
         flip = 1;
      end else if (z < -Q30_ONE) begin
         z += 64'sd1 << 31;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         k = i % 32;
         if (z >= 0) begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            z -= ARCTAN[k];
         end else begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            z += ARCTAN[k];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint cordic_angle(input longint xin, input longint yin);
      longint x, y, z, nx;
      int     k;
      x = xin;
      y = yin;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         k = i % 32;
         if (y > 0) begin
            nx = x + (y >>> k);
            y = y - (x >>> k);
            z += ARCTAN[k];
         end else begin
            nx = x - (y >>> k);
            y = y + (x >>> k);
            z -= ARCTAN[k];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] value);
      logic [63:0] v, r, b;
      v = value;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Haversine of a difference angle; also hands back the half-angle sine.
   function automatic longint half_sine_sq(input logic [31:0] d, output longint s);
      longint c;
      cordic_sincos(d >> 1, c, s);
      if (s < 0) s = -s;
      return s * s;
   endfunction

   function automatic logic [32:0] haversine_distance(input logic [31:0] lat_a,
         input logic [31:0] lon_a, input logic [31:0] lat_b,
         input logic [31:0] lon_b, input logic [22:0] radius);
      longint ca, sa, cb, sb, s_lat, s_lon, h_lat, t, u, f, theta;
      logic [63:0] r, q, w, span;
      cordic_sincos(lat_a, ca, sa);
      cordic_sincos(lat_b, cb, sb);
      h_lat = half_sine_sq(lat_b - lat_a, s_lat);
      void'(half_sine_sq(lon_b - lon_a, s_lon));
      t = (ca * cb) >>> 30;
      u = (t * s_lon) >>> 30;
      f = h_lat + u * s_lon;
      if (f < 0) f = 0;
      if (f > Q60_ONE) f = Q60_ONE;
      r = int_sqrt(f);
      q = int_sqrt(Q60_ONE - f);
      theta = cordic_angle(longint'(q), longint'(r));
      if (theta < 0) theta = 0;
      if (theta > Q30_ONE) theta = Q30_ONE;
      w = (64'(theta) * PI_HALF_Q29 + (64'd1 << 20)) >> 21;
      span = (64'(radius) * w + (64'd1 << 29)) >> 30;
      if (span > 64'(DIST_MAX)) span = 64'(DIST_MAX);
      return span[32:0];
   endfunction

   assign outstanding = expected_distance.size();

   always @(posedge clock) begin
      logic [32:0] want;
      if (reset) begin
         radius_m <= RADIUS_RESET;
         expected_distance.delete();
         mismatches <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == CSR_RADIUS)
            radius_m <= pwdata[22:0];
         if (start && !busy)
            expected_distance.push_back(haversine_distance(req_lat_a, req_lon_a,
                                        req_lat_b, req_lon_b, radius_m));
         if (rsp_valid) begin
            if (expected_distance.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response %0d with no request outstanding",
                           $realtime, rsp_distance);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_distance.pop_front();
               if (rsp_distance !== want) begin
                  if (mismatches < 10)
                     $display("%0t: distance mismatch, expected %0d, got %0d",
                              $realtime, want, rsp_distance);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

@@ bench/great_circle_distance_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_tb
// Drives directed and random coordinate pairs through the distance block
// under several sphere radii, with random request gaps, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module great_circle_distance_tb import gcd_pkg::*;;

   localparam int STAGES     = 24;
   localparam int LATENCY    = 2 * STAGES + 41;
   localparam int STALL_MAX  = 4000;
   localparam int PHASE_SIZE = 175;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [31:0] req_lat_a = 0, req_lon_a = 0, req_lat_b = 0, req_lon_b = 0;
   logic        rsp_valid;
   logic [32:0] rsp_distance;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;
   int          mismatches, outstanding;
   int          quiet_cycles;
   int          sent;
   logic [31:0] radius_plan [6];

   always #6 clock = ~clock;

   great_circle_distance #(.CORDIC_STAGES(STAGES)) DUT (.*);

   great_circle_distance_checker #(.CORDIC_STAGES(STAGES)) checker_i (.*);

   // Ends the run if neither a request nor a response moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send(input logic [31:0] la, input logic [31:0] loa,
                       input logic [31:0] lb, input logic [31:0] lob);
      bit taken;
      start <= 1;
      req_lat_a <= la;
      req_lon_a <= loa;
      req_lat_b <= lb;
      req_lon_b <= lob;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      sent++;
   endtask

   task automatic idle_gap(input bit allowed);
      if (allowed && $urandom_range(99) < 21) begin
         start <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_radius(input logic [31:0] value);
      bit ready;
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {CSR_RADIUS, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end while (!ready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   function automatic logic [31:0] rand_lat;
      // Mostly within the pole-to-pole range, sometimes any binary angle.
      if ($urandom_range(9) == 0) return $urandom;
      return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
   endfunction

   task automatic random_request(input bit allowed);
      logic [31:0] la, lb, loa, lob;
      la = rand_lat();
      loa = $urandom;
      case ($urandom_range(3))
         0: begin
            // Nearby points, where the small-angle path matters.
            lb = la + 32'($urandom_range(2000)) - 32'd1000;
            lob = loa + 32'($urandom_range(2000)) - 32'd1000;
         end
         1: begin
            // Close to antipodal.
            lb = -la + 32'($urandom_range(2000)) - 32'd1000;
            lob = loa + 32'h8000_0000 + 32'($urandom_range(2000)) - 32'd1000;
         end
         default: begin
            lb = rand_lat();
            lob = $urandom;
         end
      endcase
      send(la, loa, lb, lob);
      idle_gap(allowed);
   endtask

   initial begin
      radius_plan = '{32'd6000000, 32'd6500000, 32'd0, 32'h007F_FFFF,
                      32'hFF5B_8D80, 32'd6371000};
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed requests under the reset radius.
      send(0, 0, 0, 0);
      send(32'h4000_0000, 0, 32'hC000_0000, 0);
      send(0, 0, 0, 32'h8000_0000);
      send(32'h1234_5678, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000);
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      send(32'h4000_0000, 32'h1000_0000, 32'h4000_0000, 32'h9000_0000);
      send(32'h6000_0000, 0, 32'h6000_0000, 32'h8000_0000);
      send(32'hA000_0000, 32'h5555_5555, 32'h2000_0000, 32'hAAAA_AAAA);
      send(32'h2000_0000, 0, 32'h2000_0000, 0);
      send(0, 32'h0000_0001, 0, 0);
      drain();

      // Saturation and zero radius on the antipodal case.
      write_radius(32'h007F_FFFF);
      send(0, 0, 0, 32'h8000_0000);
      send(32'h4000_0000, 0, 32'hC000_0000, 32'h4000_0000);
      send(32'h1000_0000, 32'h0000_0000, 32'hF000_0000, 32'h8000_0000);
      drain();
      write_radius(32'd0);
      send(0, 0, 0, 32'h8000_0000);
      send(32'h3000_0000, 32'h1234_5678, 32'hD000_0000, 32'h89AB_CDEF);
      drain();
      write_radius(32'd6378137);

      for (int p = 0; p < 6; p++) begin
         for (int i = 0; i < PHASE_SIZE; i++)
            random_request(!(p == 2 && i > 20 && i < 150));
         drain();
         write_radius(radius_plan[p]);
      end
      for (int i = 0; i < 20; i++) random_request(1);

      start <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
